// ===== rtl/core/sbfec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbfec_pkg;

    localparam int CODE_W          = 7;
    localparam int OUT_W           = 8;
    localparam int DELAY_DEPTH     = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [OUT_W-1:0]  UNRECOVERABLE     = 8'd128;
    localparam logic [7:0]        ERRORS_ALLOWED_RST = 8'd8;
    localparam logic [CODE_W-1:0] ALPHA_CODE_RST     = 7'd15;
    localparam logic [CODE_W-1:0] REPEAT_CODE_RST    = 7'd102;
    localparam logic [7:0]        ERR_MAX            = 8'd255;

    localparam logic [1:0] REG_INVERT = 2'd0;
    localparam logic [1:0] REG_ERRORS = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;
    localparam logic [1:0] REG_REPEAT = 2'd3;

    typedef struct packed {
        logic              invert_bits;
        logic [7:0]        errors_allowed;
        logic [CODE_W-1:0] alpha_code;
        logic [CODE_W-1:0] repeat_code;
    } cfg_t;

    // merge = 0: rx holds a finished code to deliver as is
    typedef struct packed {
        logic              merge;
        logic [CODE_W-1:0] rx;
        logic [CODE_W-1:0] dx;
    } qentry_t;

    function automatic logic code_ok(input logic [CODE_W-1:0] v);
        logic [2:0] n;
        n = '0;
        for (int k = 0; k < CODE_W; k++) begin
            n = n + {2'b00, v[k]};
        end
        return n == 3'd4;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbfec_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbfec_queue
    import sbfec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire qentry_t wr_data,
    input  wire logic    rd_en,
    output qentry_t      rd_data,
    output logic         q_full,
    output logic         q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic do_wr;
    logic do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbfec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbfec_front
    import sbfec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        accept,
    input  wire logic [15:0] sample_value,
    output logic             q_push,
    output qentry_t          q_data
);

    logic [CODE_W-1:0] window_reg;
    logic [CODE_W-1:0] window_next;
    logic [2:0]        count_reg;
    logic [2:0]        count_next;
    logic [7:0]        err_reg;
    logic [7:0]        err_next;
    logic              phase_reg;
    logic              phase_next;
    logic [CODE_W-1:0] dly_reg [DELAY_DEPTH];
    logic [CODE_W-1:0] dly_next [DELAY_DEPTH];

    logic              bit_in;
    logic [CODE_W-1:0] win_new;
    logic              ok;
    logic [7:0]        err_mid;
    logic              phase_mid;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == ERR_MAX) ? v : v + 8'd1;
    endfunction

    always_comb begin
        window_next = window_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        phase_next  = phase_reg;
        dly_next    = dly_reg;
        q_push      = 1'b0;
        q_data      = '{merge: 1'b0, rx: '0, dx: '0};

        bit_in    = ((sample_value != '0) && !sample_value[15]) ^ cfg.invert_bits;
        win_new   = window_reg | (CODE_W'(bit_in) << count_reg);
        ok        = code_ok(win_new);
        err_mid   = ok ? 8'd0 : sat_inc(err_reg);
        phase_mid = phase_reg;

        if (accept) begin
            if (count_reg < 3'd6) begin
                window_next = win_new;
                count_next  = count_reg + 3'd1;
            end else if (!ok && (err_reg > cfg.errors_allowed)) begin
                // resync: drop oldest bit
                window_next = win_new >> 1;
                count_next  = 3'd6;
            end else begin
                window_next = '0;
                count_next  = '0;
                err_next    = err_mid;
                if (win_new == cfg.alpha_code) begin
                    phase_mid = 1'b0;
                    err_next  = '0;
                end
                if ((win_new != cfg.alpha_code) && (win_new == cfg.repeat_code)) begin
                    phase_next = 1'b0;
                    if ((dly_reg[0] == cfg.alpha_code) && (dly_reg[0] != '0)) begin
                        err_next = '0;
                        q_push   = 1'b1;
                        q_data   = '{merge: 1'b0, rx: dly_reg[0], dx: dly_reg[0]};
                    end else begin
                        err_next = sat_inc(err_mid);
                    end
                end else if (phase_mid) begin
                    phase_next = 1'b0;
                    q_push     = 1'b1;
                    q_data     = '{merge: 1'b1, rx: win_new, dx: dly_reg[0]};
                end else begin
                    phase_next = 1'b1;
                    for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
                        dly_next[i] = dly_reg[i+1];
                    end
                    dly_next[DELAY_DEPTH-1] = win_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg <= '0;
            count_reg  <= '0;
            err_reg    <= '0;
            phase_reg  <= 1'b0;
            for (int i = 0; i < DELAY_DEPTH; i++) begin
                dly_reg[i] <= '0;
            end
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
            phase_reg  <= phase_next;
            dly_reg    <= dly_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbfec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbfec_back
    import sbfec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire qentry_t     q_data,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [OUT_W-1:0] decoded_code
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CODE_W-1:0] rx_reg;
    logic [CODE_W-1:0] rx_next;
    logic [CODE_W-1:0] dx_reg;
    logic [CODE_W-1:0] dx_next;
    logic [CODE_W-1:0] trial_reg;
    logic [CODE_W-1:0] trial_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_reg;
    logic [OUT_W-1:0]  out_next;

    logic              out_free;
    logic [CODE_W-1:0] qrx;
    logic [CODE_W-1:0] qdx;
    logic [CODE_W-1:0] diff;
    logic [2:0]        ndiff;
    logic [CODE_W-1:0] sel;
    logic [CODE_W-1:0] mix;

    // place trial bits on the mismatching bit positions, lowest first
    function automatic logic [CODE_W-1:0] scatter(input logic [CODE_W-1:0] trial,
                                                  input logic [CODE_W-1:0] d);
        logic [CODE_W-1:0] s;
        logic [2:0]        idx;
        s   = '0;
        idx = '0;
        for (int k = 0; k < CODE_W; k++) begin
            if (d[k]) begin
                s[k] = trial[idx];
                idx  = idx + 3'd1;
            end
        end
        return s;
    endfunction

    assign empty        = !out_valid_reg;
    assign decoded_code = out_reg;
    assign out_free     = !out_valid_reg || pop;

    always_comb begin
        state_next     = state_reg;
        rx_next        = rx_reg;
        dx_next        = dx_reg;
        trial_next     = trial_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        q_pop          = 1'b0;

        qrx   = q_data.rx;
        qdx   = q_data.dx;
        diff  = qrx ^ qdx;
        ndiff = '0;
        for (int k = 0; k < CODE_W; k++) begin
            ndiff = ndiff + {2'b00, diff[k]};
        end
        sel = scatter(trial_reg, rx_reg ^ dx_reg);
        mix = (rx_reg & sel) | (dx_reg & ~sel);

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    if (!q_data.merge) begin
                        out_valid_next = 1'b1;
                        out_next       = OUT_W'(qrx);
                    end else if (qrx == qdx) begin
                        out_valid_next = (qrx != '0);
                        out_next       = OUT_W'(qrx);
                    end else if (code_ok(qrx)) begin
                        out_valid_next = 1'b1;
                        out_next       = OUT_W'(qrx);
                    end else if (code_ok(qdx)) begin
                        out_valid_next = 1'b1;
                        out_next       = OUT_W'(qdx);
                    end else if (code_ok(qrx | qdx)) begin
                        out_valid_next = 1'b1;
                        out_next       = OUT_W'(qrx | qdx);
                    end else if (code_ok(qrx & qdx)) begin
                        out_valid_next = 1'b1;
                        out_next       = OUT_W'(qrx & qdx);
                    end else begin
                        rx_next    = qrx;
                        dx_next    = qdx;
                        trial_next = CODE_W'((8'd1 << ndiff) - 8'd1);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (code_ok(mix)) begin
                    out_valid_next = 1'b1;
                    out_next       = OUT_W'(mix);
                    state_next     = ST_IDLE;
                end else if (trial_reg == '0) begin
                    out_valid_next = 1'b1;
                    out_next       = UNRECOVERABLE;
                    state_next     = ST_IDLE;
                end else begin
                    trial_next = trial_reg - CODE_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rx_reg        <= '0;
            dx_reg        <= '0;
            trial_reg     <= '0;
            out_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rx_reg        <= rx_next;
            dx_reg        <= dx_next;
            trial_reg     <= trial_next;
            out_reg       <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sitor_b_fec_decoder_core.sv =====
//  channel   direction  handshake                 payload
//  input     in         push / full               sample_value[15:0] signed
//  result    out        pop / empty               decoded_code[7:0]
//  config    in         APB psel/penable/pwrite   pwdata[31:0] at paddr 4*i
//
//  A sample is taken every cycle while the queue between the slicer and the
//  merge unit has room; full is high while it holds QUEUE_DEPTH requests.
//  Each queued request is resolved by the merge unit; if no direct merge gives a valid code, a
//  mismatch search of at most 2^n trials (n mismatching bits) runs and stops queue reads.
//  Results wait in a one-entry output register; an unpopped result backs up the queue.
//  rst_n is asynchronous and clears all state; config returns to defaults.
`timescale 1ns / 1ps
`default_nettype none

module sitor_b_fec_decoder_core
    import sbfec_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [15:0]      sample_value,
    output logic                  empty,
    input  wire logic             pop,
    output logic [OUT_W-1:0]      decoded_code,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t    cfg_reg;
    qentry_t q_wr_data;
    qentry_t q_rd_data;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    logic    accept;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.invert_bits    <= 1'b0;
            cfg_reg.errors_allowed <= ERRORS_ALLOWED_RST;
            cfg_reg.alpha_code     <= ALPHA_CODE_RST;
            cfg_reg.repeat_code    <= REPEAT_CODE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_INVERT: cfg_reg.invert_bits    <= pwdata[0];
                REG_ERRORS: cfg_reg.errors_allowed <= pwdata[7:0];
                REG_ALPHA:  cfg_reg.alpha_code     <= pwdata[CODE_W-1:0];
                REG_REPEAT: cfg_reg.repeat_code    <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INVERT: prdata = {31'd0, cfg_reg.invert_bits};
            REG_ERRORS: prdata = {24'd0, cfg_reg.errors_allowed};
            REG_ALPHA:  prdata = {25'd0, cfg_reg.alpha_code};
            REG_REPEAT: prdata = {25'd0, cfg_reg.repeat_code};
            default:    prdata = '0;
        endcase
    end

    sbfec_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .sample_value (sample_value),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    sbfec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    sbfec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_rd_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .decoded_code (decoded_code)
    );

endmodule

`default_nettype wire

// ===== bench/tb_sitor_b_fec_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_sitor_b_fec_decoder_core;
    import sbfec_pkg::*;

    localparam int QUIET_CYCLES = 300;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic [15:0] smp;
        bit          hold;
    } sample_req_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              push         = 1'b0;
    logic [15:0]       sample_value = '0;
    logic              pop          = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [3:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic              full;
    logic              empty;
    logic [OUT_W-1:0]  decoded_code;
    logic [31:0]       prdata;
    logic              pready;

    // shadow registers
    bit                sh_invert  = 1'b0;
    bit [7:0]          sh_err_lim = ERRORS_ALLOWED_RST;
    bit [CODE_W-1:0]   sh_alpha   = ALPHA_CODE_RST;
    bit [CODE_W-1:0]   sh_repeat  = REPEAT_CODE_RST;

    // decoder state
    bit [CODE_W-1:0]   win;
    bit [2:0]          nbits;
    bit [7:0]          err_run;
    bit                rx_turn;
    bit [CODE_W-1:0]   dx_line [DELAY_DEPTH];

    sample_req_t       pending_q[$];
    bit [OUT_W-1:0]    expected_codes[$];

    int                send_gap_pct  = 0;
    int                pop_stall_pct = 0;
    int                fails         = 0;
    int                n_samples     = 0;
    int                n_codes       = 0;
    int                n_settings    = 0;
    int                quiet_cnt     = 0;

    sitor_b_fec_decoder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_value (sample_value),
        .empty        (empty),
        .pop          (pop),
        .decoded_code (decoded_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit four_ones(input bit [CODE_W-1:0] v);
        return $countones(v) == 4;
    endfunction

    function automatic bit [CODE_W-1:0] valid_code();
        bit [CODE_W-1:0] v;
        do v = CODE_W'($urandom_range(127)); while (!four_ones(v));
        return v;
    endfunction

    // mismatching bits tried from all-RX down to all-DX
    function automatic bit [OUT_W-1:0] best_mix(input bit [CODE_W-1:0] rxc,
                                                 input bit [CODE_W-1:0] dxc);
        bit [CODE_W-1:0] diff;
        bit [CODE_W-1:0] sel;
        bit [CODE_W-1:0] v;
        int              idx [CODE_W];
        int              n;
        diff = rxc ^ dxc;
        n = 0;
        for (int k = 0; k < CODE_W; k++)
        begin
            if (diff[k])
            begin
                idx[n] = k;
                n++;
            end
        end
        if (n == 0)
            return {1'b0, rxc};
        for (int t = (1 << n) - 1; t >= 0; t--)
        begin
            sel = '0;
            for (int k = 0; k < n; k++)
            begin
                if ((t >> k) & 1)
                    sel[idx[k]] = 1'b1;
            end
            v = (rxc & sel) | (dxc & ~sel);
            if (four_ones(v))
                return {1'b0, v};
        end
        return UNRECOVERABLE;
    endfunction

    function automatic bit [OUT_W-1:0] time_diversity(input bit [CODE_W-1:0] code);
        bit [CODE_W-1:0] c1;
        bit [OUT_W-1:0]  r;
        c1 = dx_line[0];
        r = '0;
        if (code == sh_alpha)
        begin
            rx_turn = 1'b0;
            err_run = '0;
        end
        else if (code == sh_repeat)
        begin
            r = (c1 == sh_alpha) ? {1'b0, c1} : '0;
            rx_turn = 1'b0;
            if (r != 0)
                err_run = '0;
            else if (err_run != ERR_MAX)
                err_run++;
            return r;
        end
        if (rx_turn)
        begin
            if (c1 == code || four_ones(code))
                r = {1'b0, code};
            else if (four_ones(c1))
                r = {1'b0, c1};
            else if (four_ones(c1 | code))
                r = {1'b0, c1 | code};
            else if (four_ones(c1 & code))
                r = {1'b0, c1 & code};
            else
                r = best_mix(code, c1);
        end
        else
        begin
            dx_line[0] = dx_line[1];
            dx_line[1] = dx_line[2];
            dx_line[2] = code;
        end
        rx_turn = ~rx_turn;
        return r;
    endfunction

    task automatic predict_sample(input logic [15:0] s);
        bit              b;
        bit              ok;
        bit [CODE_W-1:0] code;
        bit [OUT_W-1:0]  r;
        b = (s != 0 && !s[15]) ^ sh_invert;
        win[nbits] = win[nbits] | b;
        nbits++;
        if (nbits < 7)
            return;
        code = win;
        ok = four_ones(code);
        if (!ok && err_run > sh_err_lim)
        begin
            win = win >> 1;
            nbits = 3'd6;
            return;
        end
        win = '0;
        nbits = '0;
        if (ok)
            err_run = '0;
        else if (err_run != ERR_MAX)
            err_run++;
        r = time_diversity(code);
        if (r != 0)
            expected_codes.push_back(r);
    endtask

    // driver
    always @(posedge clk)
    begin
        sample_req_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_sample(sample_value);
                n_samples++;
            end
            if (!push || !full)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct
                    && !(pending_q[0].hold && expected_codes.size() != 0))
                begin
                    nxt = pending_q.pop_front();
                    push <= 1'b1;
                    sample_value <= nxt.smp;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        bit [OUT_W-1:0] want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                n_codes++;
                if (expected_codes.size() == 0)
                begin
                    $error("decoded_code: expected none, got %0d", decoded_code);
                    fails++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (decoded_code !== want)
                    begin
                        $error("decoded_code: expected %0d, got %0d", want, decoded_code);
                        fails++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cnt <= 0;
        end
        else
        begin
            quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt == STALL_LIMIT)
            begin
                $display("tb_sitor_b_fec_decoder_core: FAIL");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input bit inv, input bit [7:0] lim,
                              input bit [CODE_W-1:0] a, input bit [CODE_W-1:0] r);
        apb_write(REG_INVERT, {31'd0, inv});
        apb_write(REG_ERRORS, {24'd0, lim});
        apb_write(REG_ALPHA, {25'd0, a});
        apb_write(REG_REPEAT, {25'd0, r});
        sh_invert  = inv;
        sh_err_lim = lim;
        sh_alpha   = a;
        sh_repeat  = r;
        n_settings++;
        @(negedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int stall_pct);
        send_gap_pct  = send_pct;
        pop_stall_pct = stall_pct;
    endtask

    function automatic logic [15:0] sample_for(input bit one);
        if (one)
            return 16'($urandom_range(32767, 1));
        if ($urandom_range(3) == 0)
            return 16'h0000;
        return 16'h8000 | 16'($urandom_range(32767));
    endfunction

    task automatic push_code(input bit [CODE_W-1:0] c);
        for (int k = 0; k < CODE_W; k++)
            pending_q.push_back('{sample_for(c[k] ^ sh_invert), 1'b0});
    endtask

    task automatic queue_traffic(input int n_sym, input int hold_at);
        bit [CODE_W-1:0] recent[$];
        bit [CODE_W-1:0] c;
        int              pick;
        int              first;
        for (int i = 0; i < n_sym; i++)
        begin
            first = pending_q.size();
            pick = $urandom_range(99);
            if (pick < 7)
                c = sh_alpha;
            else if (pick < 11)
                c = sh_repeat;
            else if (pick < 14)
                c = '0;
            else if (pick < 19)
            begin
                // misalign by a short burst of noise
                repeat ($urandom_range(3, 1))
                    pending_q.push_back('{16'($urandom), 1'b0});
                c = valid_code();
            end
            else if (pick < 42 && recent.size() >= 5)
            begin
                // RX copy of the DX symbol five slots back, maybe hit by noise
                c = recent[recent.size() - 5];
                repeat ($urandom_range(3))
                    c ^= CODE_W'(1 << $urandom_range(CODE_W - 1));
            end
            else if (pick < 58)
                c = CODE_W'($urandom_range(127));
            else if (pick < 94)
                c = valid_code();
            else
            begin
                // phasing run: alpha reaches the delay head just before repeat
                push_code(sh_alpha);
                recent.push_back(sh_alpha);
                repeat (4)
                begin
                    c = valid_code();
                    push_code(c);
                    recent.push_back(c);
                end
                c = sh_repeat;
            end
            push_code(c);
            recent.push_back(c);
            if (i == hold_at)
                pending_q[first].hold = 1'b1;
        end
    endtask

    // all-zero symbols are invalid at any bit alignment
    task automatic queue_zero_run(input int n_sym);
        repeat (n_sym)
            push_code('0);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || push || expected_codes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        bit [CODE_W-1:0] v;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: extreme samples, then alpha and repeat symbols
        set_idle(0, 0);
        pending_q.push_back('{16'h7FFF, 1'b0});
        pending_q.push_back('{16'h0001, 1'b0});
        pending_q.push_back('{16'hFFFF, 1'b0});
        pending_q.push_back('{16'h8000, 1'b0});
        pending_q.push_back('{16'h0000, 1'b0});
        pending_q.push_back('{16'h7FFF, 1'b0});
        pending_q.push_back('{16'h0001, 1'b0});
        push_code(sh_alpha);
        push_code(sh_repeat);
        queue_traffic(16, -1);
        drain();

        set_config(1'b1, 8'd0, 7'd15, 7'd102);
        set_idle(87, 0);
        queue_traffic(16, -1);
        drain();

        // zero symbols fill the delay line with zeros
        set_config(1'b0, 8'd255, 7'd15, 7'd102);
        set_idle(0, 0);
        queue_traffic(10, -1);
        queue_zero_run(7);
        drain();

        // zero is now also the repeat symbol: two error steps per symbol
        set_config(1'b0, 8'd255, 7'd15, 7'd0);
        queue_zero_run(130);
        drain();

        // error count left saturated: resync starts at once
        set_config(1'b1, 8'd254, 7'd127, 7'd0);
        set_idle(0, 87);
        queue_traffic(16, 8);
        drain();

        set_config(1'b0, 8'd3, 7'd0, 7'd127);
        set_idle(10, 10);
        queue_traffic(16, -1);
        drain();

        v = valid_code();
        set_config(1'b0, 8'd8, v, v);
        set_idle(0, 0);
        queue_traffic(16, -1);
        drain();

        $display("%0d samples driven, %0d decoded codes checked across %0d register settings",
                 n_samples, n_codes, n_settings + 1);
        if (fails == 0 && expected_codes.size() == 0)
            $display("tb_sitor_b_fec_decoder_core: PASS");
        else
            $display("tb_sitor_b_fec_decoder_core: FAIL");
        $finish;
    end

endmodule

// ===== sitor_b_fec_decoder_core.f =====
rtl/core/sbfec_pkg.sv
rtl/core/sbfec_queue.sv
rtl/core/sbfec_front.sv
rtl/core/sbfec_back.sv
rtl/core/sitor_b_fec_decoder_core.sv
bench/tb_sitor_b_fec_decoder_core.sv
